FILE: rtl/sha256_message_digest_assert.svh
// assertion macros used by the checker file
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// property checked on every clock edge outside reset
`define SMD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SMD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Types, constants and round functions of the SHA-256 message digest block.
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned AddrBits   = 6;
   localparam int unsigned WordBits   = 32;
   localparam int unsigned Rounds     = 64;
   localparam int unsigned DigestWords = 8;
   localparam logic [5:0]  LengthPos  = 6'd56;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_item;
      logic       no_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        final_word;
   } rsp_type;

   // round constants
   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      begin
         unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
         endcase
         return k;
      end
   endfunction

   // initial hash values
   function automatic word_type init_h(input logic [2:0] idx);
      word_type h;
      begin
         unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
         endcase
         return h;
      end
   endfunction

   function automatic word_type ror(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WordBits - n));
   endfunction

endpackage

FILE: rtl/smd_stream_if.sv
// ----------------------------------------------------------------------------
// smd_stream_if
// Valid/ready channels carrying one request or one response payload.
// ----------------------------------------------------------------------------
interface smd_req_if;
   logic                 valid;
   logic                 ready;
   smd_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface smd_rsp_if;
   logic                 valid;
   logic                 ready;
   smd_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 hash of a byte stream, eight digest words per message.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one message byte per transfer, with last_item marking the
//   end and no_byte marking a transfer that carries no byte.
//   rsp channel: eight digest words, word_number 0 to 7, final_word on 7.
//   Bytes are written to a 64-byte store one per cycle. On every 64th byte
//   the compression unit runs: a start step, the schedule load from the
//   store (one read port, one byte per cycle, registered read), 64 rounds
//   and a fold into the chain, and no byte is taken while it runs.
//   The last transfer also writes padding and length, one byte per cycle
//   when the compression unit is idle, which may add a second block; the
//   digest follows the last fold, one word per cycle while the receiver is ready.
//   Reset brings back the initial hash, zero length and an empty store.
//   A stalled receiver holds the current word; no request is taken until
//   all eight words are transferred.
// ----------------------------------------------------------------------------
module sha256_message_digest (
   input logic         clock,
   input logic         reset,
   smd_req_if.sink     req,
   smd_rsp_if.source   rsp
);
   typedef enum logic [2:0] {S_IN, S_PAD, S_LEN, S_WAIT, S_OUT} state_type;

   state_type    state_ff;
   logic [5:0]   fill_ff;
   logic [63:0]  count_ff, len_ff;
   logic [2:0]   lenix_ff, word_ff;
   logic         last_ff;
   logic         wr_en;
   logic [7:0]   wr_data;
   logic [5:0]   rd_addr;
   logic [7:0]   rd_data;
   logic         start_ff, busy, clear_chain;
   logic [31:0]  chain_word;
   logic         take;

   smd_ram #(.Width(8), .Depth(smd_pkg::BlockBytes)) u_store (
      .clock, .wr_en, .wr_addr(fill_ff), .wr_data, .rd_addr, .rd_data
   );

   smd_compress u_comp (
      .clock, .reset, .start(start_ff), .clear_chain, .busy, .rd_addr, .rd_data,
      .chain_sel(word_ff), .chain_word
   );

   assign req.ready = (state_ff == S_IN) && !busy && !start_ff;
   assign take      = req.valid && req.ready;

   // store writes from input, padding and length bytes
   always_comb begin
      wr_en   = 1'b0;
      wr_data = req.payload.data_byte;
      unique case (state_ff)
         S_IN:  wr_en = take && !req.payload.no_byte;
         S_PAD: begin
            wr_en   = !busy && !start_ff;
            wr_data = last_ff ? smd_pkg::PadByte : 8'd0;
         end
         S_LEN: begin
            wr_en   = !busy && !start_ff;
            wr_data = len_ff[63:56];
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign clear_chain = (state_ff == S_OUT) && rsp.ready && (word_ff == 3'd7);

   // control sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
         fill_ff  <= '0;
         count_ff <= '0;
         word_ff  <= '0;
         start_ff <= 1'b0;
         last_ff  <= 1'b0;
         lenix_ff <= '0;
      end else begin
         start_ff <= wr_en && (fill_ff == 6'd63);
         if (wr_en) fill_ff <= fill_ff + 6'd1;
         unique case (state_ff)
            S_IN: begin
               if (take) begin
                  if (!req.payload.no_byte) count_ff <= count_ff + 64'd8;
                  if (req.payload.last_item) begin
                     state_ff <= S_PAD;
                     last_ff  <= 1'b1;
                     len_ff   <= count_ff + (req.payload.no_byte ? 64'd0 : 64'd8);
                  end
               end
            end
            S_PAD: begin
               if (wr_en) begin
                  last_ff <= 1'b0;
                  if (fill_ff + 6'd1 == smd_pkg::LengthPos) begin
                     state_ff <= S_LEN;
                     lenix_ff <= '0;
                  end
               end
            end
            S_LEN: begin
               if (wr_en) begin
                  len_ff   <= {len_ff[55:0], 8'd0};
                  lenix_ff <= lenix_ff + 3'd1;
                  if (lenix_ff == 3'd7) state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (!busy && !start_ff) begin
                  state_ff <= S_OUT;
                  word_ff  <= '0;
               end
            end
            default: begin
               if (rsp.ready) begin
                  word_ff <= word_ff + 3'd1;
                  if (word_ff == 3'd7) begin
                     state_ff <= S_IN;
                     count_ff <= '0;
                  end
               end
            end
         endcase
      end
   end

   assign rsp.valid               = (state_ff == S_OUT);
   assign rsp.payload.digest_word = chain_word;
   assign rsp.payload.word_number = word_ff;
   assign rsp.payload.final_word  = (word_ff == 3'd7);
endmodule

FILE: rtl/smd_ram.sv
// ----------------------------------------------------------------------------
// smd_ram
// Generic simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module smd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/smd_compress.sv
// ----------------------------------------------------------------------------
// smd_compress
// SHA-256 compression over a 64-byte block held in the block store.
// Reads one byte per cycle from the registered read port, building a 16-word
// schedule window, then runs 64 rounds, one per cycle, and folds the result
// into the chain.
// ----------------------------------------------------------------------------
module smd_compress (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        clear_chain,
   output logic        busy,
   output logic [5:0]  rd_addr,
   input  logic [7:0]  rd_data,
   input  logic [2:0]  chain_sel,
   output logic [31:0] chain_word
);
   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_FOLD} state_type;

   state_type          state_ff, state_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [31:0]        w_ff [16];
   logic [31:0]        w_in [16];
   logic [31:0]        s_ff [8];
   logic [31:0]        s_in [8];
   logic [31:0]        h_ff [8];
   logic [31:0]        h_in [8];

   logic [31:0] w_cur, w_new, sg0, sg1, big0, big1, ch, maj, t1, t2;

   // schedule word for this round, next schedule word and round terms
   always_comb begin
      w_cur = w_ff[0];
      sg0 = smd_pkg::ror(w_ff[1], 7) ^ smd_pkg::ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sg1 = smd_pkg::ror(w_ff[14], 17) ^ smd_pkg::ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + sg0 + w_ff[9] + sg1;
      big1 = smd_pkg::ror(s_ff[4], 6) ^ smd_pkg::ror(s_ff[4], 11) ^ smd_pkg::ror(s_ff[4], 25);
      ch = (s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]);
      t1 = s_ff[7] + big1 + ch + smd_pkg::round_k(cnt_ff[5:0]) + w_cur;
      big0 = smd_pkg::ror(s_ff[0], 2) ^ smd_pkg::ror(s_ff[0], 13) ^ smd_pkg::ror(s_ff[0], 22);
      maj = (s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]);
      t2 = big0 + maj;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      w_in     = w_ff;
      s_in     = s_ff;
      h_in     = h_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_LOAD;
               cnt_in   = '0;
            end
         end
         S_LOAD: begin
            // read data is registered, so it lags the address; bytes arrive at cnt 1..64
            if (cnt_ff != 7'd0) begin
               // a new word starts with every fourth byte
               if (cnt_ff[1:0] == 2'd1) begin
                  for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
               end
               w_in[15] = {w_ff[15][23:0], rd_data};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               state_in = S_ROUND;
               cnt_in   = '0;
               s_in     = h_ff;
            end
         end
         S_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = w_new;
            s_in[7] = s_ff[6]; s_in[6] = s_ff[5]; s_in[5] = s_ff[4];
            s_in[4] = s_ff[3] + t1;
            s_in[3] = s_ff[2]; s_in[2] = s_ff[1]; s_in[1] = s_ff[0];
            s_in[0] = t1 + t2;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               state_in = S_FOLD;
            end
         end
         default: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + s_ff[i];
            state_in = S_IDLE;
         end
      endcase
      if (clear_chain) begin
         for (int i = 0; i < 8; i++) h_in[i] = smd_pkg::init_h(3'(i));
      end
   end

   // state, counter and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= smd_pkg::init_h(3'(i));
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         h_ff     <= h_in;
      end
      w_ff <= w_in;
      s_ff <= s_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rd_addr    = cnt_ff[5:0];
   assign chain_word = h_ff[chain_sel];
endmodule

FILE: rtl/smd_checker.sv
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the message digest block.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_assert.svh"

module smd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input smd_pkg::rsp_type rsp_payload
);
   logic       rsp_take;
   logic [2:0] word_num;

   assign rsp_take = rsp_valid && rsp_ready;
   assign word_num = rsp_payload.word_number;

   // final flag marks word seven only
   property p_final;
      rsp_valid |-> (rsp_payload.final_word == (word_num == 3'd7));
   endproperty

   // word numbers step by one per transfer
   property p_step;
      (rsp_take && !rsp_payload.final_word)
         |=> (rsp_valid && word_num == $past(word_num) + 3'd1);
   endproperty

   // no request taken while a digest is being sent
   `SMD_ASSERT(a_no_overlap, rsp_valid |-> !req_ready, "request accepted during digest")
   `SMD_ASSERT(a_final, p_final, "final flag mismatch")
   `SMD_ASSERT(a_step, p_step, "word order broken")
   // stalled word holds
   `SMD_ASSERT(a_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)), "stalled word changed")
endmodule

bind sha256_message_digest smd_checker u_smd_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

FILE: tb/smd_digest_board.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smd_digest_board
// Tracks accepted message bytes, computes the expected SHA-256 digest words
// and compares them with the words that leave the block.
// ----------------------------------------------------------------------------
class smd_digest_board;

   logic [7:0]  msg_block [64];
   logic [31:0] chain [8];
   logic [63:0] length_bits;
   int unsigned fill;
   smd_pkg::rsp_type pending_words [$];
   int unsigned mismatch_count;

   function new();
      mismatch_count = 0;
      restart();
   endfunction

   function void restart();
      for (int i = 0; i < 8; i++) chain[i] = smd_pkg::init_h(i[2:0]);
      length_bits = '0;
      fill = 0;
   endfunction

   function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of the collected block
   function void compress();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] t1, t2, x, y;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         x = w[i-15];
         y = w[i-2];
         w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
              + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
      end
      for (int i = 0; i < 8; i++) s[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + smd_pkg::round_k(i[5:0]) + w[i];
         t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
         s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += s[i];
   endfunction

   function void absorb(logic [7:0] b);
      msg_block[fill] = b;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
   endfunction

   // accepted input transfer
   function void note_request(smd_pkg::req_type r);
      logic [63:0] len;
      smd_pkg::rsp_type word;
      if (!r.no_byte) begin
         absorb(r.data_byte);
         length_bits += 64'd8;
      end
      if (r.last_item) begin
         len = length_bits;
         absorb(smd_pkg::PadByte);
         while (fill != 56) absorb(8'h00);
         for (int i = 0; i < 8; i++) absorb(len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            word.digest_word = chain[i];
            word.word_number = i[2:0];
            word.final_word  = (i == 7);
            pending_words.insert(pending_words.size(), word);
         end
         restart();
      end
   endfunction

   // accepted result transfer
   function void check_word(smd_pkg::rsp_type got);
      smd_pkg::rsp_type want;
      if (pending_words.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected digest word %h #%0d", got.digest_word, got.word_number);
         return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("digest word: expected %h #%0d f%0b, got %h #%0d f%0b",
                     want.digest_word, want.word_number, want.final_word,
                     got.digest_word, got.word_number, got.final_word);
      end
   endfunction

endclass

FILE: tb/sha256_message_digest_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_message_digest_test
// Feeds byte messages of varied lengths with random gaps and stalls and
// checks every digest word against a behavioral SHA-256 computation.
// ----------------------------------------------------------------------------
module sha256_message_digest_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off = 1'b0;
   logic sending_done = 1'b0;

   smd_req_if req ();
   smd_rsp_if rsp ();

   smd_digest_board board = new();

   sha256_message_digest dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #2 clock = ~clock;

   // run limit
   initial begin
      #20ms;
      $display("sha256_message_digest: mismatch");
      $finish;
   end

   // transfer monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_request(req.payload);
         if (rsp.valid && rsp.ready) board.check_word(rsp.payload);
      end
   end

   // result side: random wait per word, plus one long hold-off
   initial begin
      int unsigned wait_cycles;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            wait_cycles = $urandom_range(0, 3);
            if (wait_cycles != 0) begin
               rsp.ready <= 1'b0;
               repeat (wait_cycles) @(negedge clock);
            end
            rsp.ready <= 1'b1;
            @(posedge clock);
            while (!(rsp.valid && rsp.ready)) @(posedge clock);
            @(negedge clock);
         end
      end
   end

   // one input transfer; valid stays up until the next item or a drain
   task automatic send_item(logic [7:0] b, logic last, logic none, bit gaps);
      smd_pkg::req_type r;
      int unsigned gap;
      r.data_byte = b;
      r.last_item = last;
      r.no_byte   = none;
      gap = gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // message of random bytes, sprinkled with empty transfers
   task automatic send_message(int unsigned len, bit gaps, bit empty_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b1, gaps);
         if (i == len - 1 && !empty_end) send_item(8'($urandom), 1'b1, 1'b0, gaps);
         else send_item(8'($urandom), 1'b0, 1'b0, gaps);
      end
      if (empty_end || len == 0) send_item(8'($urandom), 1'b1, 1'b1, gaps);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.pending_words.size() != 0) @(negedge clock);
   endtask

   int unsigned sent;
   int unsigned len;

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed: empty message, one byte, byte extremes, empty transfers, three-byte messages
      send_message(0, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b0, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1, 1'b0);
      send_item(8'ha5, 1'b1, 1'b1, 1'b0);
      send_message(3, 1'b0, 1'b0);
      send_message(3, 1'b0, 1'b1);
      wait_drained();

      // sender keeps offering while the receiver holds off
      hold_off = 1'b1;
      sent = 0;
      while (sent < 20) begin
         send_item(8'($urandom), 1'b1, 1'b0, 1'b0);
         sent++;
      end
      wait_drained();

      // random: short lengths and lengths around block and padding boundaries
      sent = 0;
      while (sent < 210) begin
         case ($urandom_range(0, 5))
            0: len = $urandom_range(54, 57);
            1: len = $urandom_range(63, 65);
            2: len = $urandom_range(118, 129);
            default: len = $urandom_range(0, 12);
         endcase
         send_message(len, 1'b1, $urandom_range(0, 2) == 0);
         sent += len + 1;
      end

      wait_drained();
      repeat (400) @(negedge clock);
      sending_done = 1'b1;
   end

   // final verdict
   initial begin
      wait (sending_done);
      if (board.mismatch_count == 0 && board.pending_words.size() == 0)
         $display("sha256_message_digest: match");
      else
         $display("sha256_message_digest: mismatch");
      $finish;
   end

endmodule
